>>> design/pacs_pkg.sv
// ----------------------------------------------------------------------------
// pacs_pkg
// Types and constants shared by the POV arc column sequencer.
// ----------------------------------------------------------------------------
package pacs_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_HALL  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_PHASE_SHIFT    = 2'd0;
  localparam logic [1:0] CFG_INITIAL_PERIOD = 2'd1;

  // Register reset values
  localparam logic [7:0]  PHASE_SHIFT_RST    = 8'd64;
  localparam logic [15:0] INITIAL_PERIOD_RST = 16'd16383;

  // Fixed geometry: 256 arcs per turn, 8 arcs per image byte, 32 bytes per row
  localparam int unsigned ARCS_PER_TURN = 256;
  localparam int unsigned ROW_BYTES     = 32;
  localparam int unsigned MAX_LEDS      = 16;
  localparam logic [14:0] DRAWN_MAX     = 15'h7fff;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] led_index;
    logic [4:0] byte_index;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] led_column;
    logic [7:0]  arc_index;
  } out_item_t;

endpackage

>>> design/pov_arc_column_sequencer_unit.sv
// ----------------------------------------------------------------------------
// pov_arc_column_sequencer_unit
// Rotating-LED column sequencer: arc timer, hall-pulse period correction and
// a 32 x (8*LED_COUNT) image memory that yields one LED column per arc.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_item_i) carries ticks, hall
//   pulses and image byte writes, one item per cycle while in_ready_o is high.
//   Output channel (out_valid_o/out_ready_i, out_item_o) carries one column
//   for every tick that ends an arc; other items produce nothing.
//   Configuration (cfg_we_i, cfg_index_i, cfg_data_i) is written while idle;
//   writing initial_period also reloads the arc period.
// Pipeline: after its tick is accepted, a column passes the synchronous
//   image memory read stage, then the output register that picks the bit
//   of each LED lane, before it appears on out_valid_o.
// Throughput: one item per cycle while in_ready_o is high. The read stage
//   plus the output register hold two columns, so input stays ready while
//   one column waits; it drops only when both are full and out_ready_i is low.
// Reset: registers take their reset values, then a clearing pass writes the
//   32 image rows to zero, one row a cycle; in_ready_o stays low for the
//   whole pass. Configuration writes are taken during the pass.
// ----------------------------------------------------------------------------
module pov_arc_column_sequencer_unit #(
  parameter int unsigned LED_COUNT = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pacs_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pacs_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import pacs_pkg::*;

  localparam int unsigned LANE_W = 8 * LED_COUNT;
  localparam int unsigned ADDR_W = $clog2(ROW_BYTES);

  // Configuration and scalar state
  logic [7:0]  phase_shift_q;
  logic [15:0] tick_count_q, tick_count_d;
  logic [15:0] arc_period_q, arc_period_d;
  logic [14:0] drawn_count_q, drawn_count_d;
  logic [7:0]  arc_position_q, arc_position_d;

  // Clearing pass counter: top bit set once all rows are cleared
  logic [ADDR_W:0] clr_cnt_q;
  logic            clearing;

  // Image memory: row = byte index, lane = LED
  logic [LANE_W-1:0] image_mem [ROW_BYTES];
  logic [LANE_W-1:0] rdata_q;

  // Read stage and output stage
  logic        a_valid_q;
  logic [7:0]  a_arc_q;
  logic [2:0]  a_bit_q;
  logic        b_valid_q;
  out_item_t   b_item_q;
  logic        a_hold, a_move;

  logic        accept, is_tick, is_hall, is_write, fire;
  logic [15:0] tick_inc;
  logic [15:0] col;

  assign clearing = !clr_cnt_q[ADDR_W];
  assign a_move   = a_valid_q && (!b_valid_q || out_ready_i);
  assign a_hold   = a_valid_q && b_valid_q && !out_ready_i;

  assign in_ready_o = !clearing && !a_hold;
  assign accept     = in_valid_i && in_ready_o;
  assign is_tick    = accept && (in_item_i.req_type == REQ_TICK);
  assign is_hall    = accept && (in_item_i.req_type == REQ_HALL);
  assign is_write   = accept && (in_item_i.req_type == REQ_WRITE);
  assign tick_inc   = tick_count_q + 16'd1;
  assign fire       = is_tick && (tick_inc == arc_period_q);

  // Next state of the timer, period, count and arc position
  always_comb begin
    tick_count_d   = tick_count_q;
    arc_period_d   = arc_period_q;
    drawn_count_d  = drawn_count_q;
    arc_position_d = arc_position_q;
    if (is_tick) begin
      tick_count_d = fire ? 16'd0 : tick_inc;
      if (fire) begin
        if (drawn_count_q < DRAWN_MAX) drawn_count_d = drawn_count_q + 15'd1;
        arc_position_d = arc_position_q + 8'd1;
      end
    end else if (is_hall) begin
      tick_count_d   = 16'd0;
      arc_period_d   = arc_period_q + {1'b0, drawn_count_q} - 16'(ARCS_PER_TURN);
      drawn_count_d  = 15'd0;
      arc_position_d = phase_shift_q;
    end
    if (cfg_we_i && (cfg_index_i == CFG_INITIAL_PERIOD)) begin
      arc_period_d = cfg_data_i;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_shift_q  <= PHASE_SHIFT_RST;
      tick_count_q   <= 16'd0;
      arc_period_q   <= INITIAL_PERIOD_RST;
      drawn_count_q  <= 15'd0;
      arc_position_q <= 8'd0;
      clr_cnt_q      <= '0;
      a_valid_q      <= 1'b0;
      b_valid_q      <= 1'b0;
    end else begin
      tick_count_q   <= tick_count_d;
      arc_period_q   <= arc_period_d;
      drawn_count_q  <= drawn_count_d;
      arc_position_q <= arc_position_d;
      if (cfg_we_i && (cfg_index_i == CFG_PHASE_SHIFT)) phase_shift_q <= cfg_data_i[7:0];
      if (clearing) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (fire) a_valid_q <= 1'b1;
      else if (a_move) a_valid_q <= 1'b0;
      if (a_move) b_valid_q <= 1'b1;
      else if (out_ready_i) b_valid_q <= 1'b0;
    end
  end

  // Image memory write port: clearing pass, else one byte lane
  always_ff @(posedge clk_i) begin
    if (clearing) begin
      image_mem[clr_cnt_q[ADDR_W-1:0]] <= '0;
    end else if (is_write) begin
      for (int l = 0; l < LED_COUNT; l++) begin
        if (in_item_i.led_index == 4'(l)) begin
          image_mem[in_item_i.byte_index][l*8 +: 8] <= in_item_i.byte_value;
        end
      end
    end
  end

  // Image memory read port, loaded by the tick that ends an arc
  always_ff @(posedge clk_i) begin
    if (fire) begin
      rdata_q <= image_mem[arc_position_q[7:3]];
      a_arc_q <= arc_position_q;
      a_bit_q <= arc_position_q[2:0];
    end
  end

  // Pick one bit per LED lane; lanes beyond LED_COUNT read zero
  always_comb begin
    col = '0;
    for (int l = 0; l < MAX_LEDS; l++) begin
      if (l < LED_COUNT) col[l] = rdata_q[l*8 + int'(a_bit_q)];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_item_q.led_column <= col;
      b_item_q.arc_index  <= a_arc_q;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_item_o  = b_item_q;

  // A held read stage keeps its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_hold |=> $stable(rdata_q) && $stable(a_arc_q))
    else $error("read stage changed while held");

  // A firing tick fills the read stage and restarts the timer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> a_valid_q && (tick_count_q == 16'd0))
    else $error("firing tick not registered");

  // A hall pulse clears the timer and the drawn count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_hall |=> (tick_count_q == 16'd0) && (drawn_count_q == 15'd0))
    else $error("hall pulse did not clear state");

  // No item is taken while the image is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !accept && !a_valid_q && !b_valid_q)
    else $error("activity during clearing pass");

endmodule
